>>> hw/rtl/bpq_pkg.sv
// bpq_pkg: shared types and constants for the bounded priority queue
// no dependencies; imported by every module of the block except bpq_fifo
`default_nettype none

package bpq_pkg;

    localparam int CNT_W = 6;

    localparam logic [1:0] MODE_PUSH = 2'd0;
    localparam logic [1:0] MODE_POP  = 2'd1;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_PUSH_FULL  = 2'd1;
    localparam logic [1:0] ST_POP_EMPTY  = 2'd2;

    localparam logic signed [31:0] PRIO_MIN = {1'b1, 31'd0};

    localparam logic [CNT_W-1:0] CAP_RESET = 6'd32;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_POP,
        OP_STATUS
    } t_op;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_REPORT
    } t_bk_state;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] push_value;
        logic signed [31:0] push_priority;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] front_value;
        logic signed [31:0] front_priority;
        logic [CNT_W-1:0]   entry_count;
        logic               is_empty;
        logic               is_full;
        logic [1:0]         status;
    } t_result;

    typedef struct packed {
        t_op                op;
        logic signed [31:0] value;
        logic signed [31:0] prio;
    } t_cmd;

    typedef struct packed {
        logic signed [31:0] prio;
        logic signed [31:0] value;
    } t_entry;

endpackage

`default_nettype wire

>>> hw/rtl/bpq_fifo.sv
// bpq_fifo: two-entry queue used between the front, the back and the result port
// no package dependency
`default_nettype none

module bpq_fifo #(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_wr,
    input  wire logic [W-1:0] i_wdata,
    output logic              o_full,
    input  wire logic         i_rd,
    output logic [W-1:0]      o_rdata,
    output logic              o_empty
);

    logic [W-1:0] r_buf [2];
    logic         r_wr_ptr;
    logic         r_rd_ptr;
    logic [1:0]   r_count;
    logic         wr_en;
    logic         rd_en;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_rdata = r_buf[r_rd_ptr];
    assign wr_en   = i_wr & ~o_full;
    assign rd_en   = i_rd & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (rd_en) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_buf[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/bpq_front.sv
// bpq_front: takes items, decodes the mode into a command and queues it
// depends on bpq_pkg and bpq_fifo
`default_nettype none

module bpq_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  bpq_pkg::t_in_item    i_item,
    output logic                 o_full,
    output logic                 o_cmd_valid,
    output bpq_pkg::t_cmd        o_cmd,
    input  wire logic            i_cmd_take
);
    import bpq_pkg::*;

    t_cmd                 dec_cmd;
    logic [$bits(t_cmd)-1:0] q_rdata;
    logic                 q_empty;

    // mode three counts as status only
    always_comb begin
        dec_cmd.value = i_item.push_value;
        dec_cmd.prio  = i_item.push_priority;
        case (i_item.mode)
            MODE_PUSH: dec_cmd.op = OP_PUSH;
            MODE_POP:  dec_cmd.op = OP_POP;
            default:   dec_cmd.op = OP_STATUS;
        endcase
    end

    bpq_fifo #(
        .W ($bits(t_cmd))
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_push),
        .i_wdata (dec_cmd),
        .o_full  (o_full),
        .i_rd    (i_cmd_take),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    assign o_cmd_valid = ~q_empty;
    assign o_cmd       = t_cmd'(q_rdata);

endmodule

`default_nettype wire

>>> hw/rtl/bpq_back.sv
// bpq_back: executes commands against the entry memory and builds results
// depends on bpq_pkg
`default_nettype none

module bpq_back #(
    parameter int DEPTH = 32
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cmd_valid,
    input  bpq_pkg::t_cmd                  i_cmd,
    output logic                           o_cmd_take,
    input  wire logic                      i_res_space,
    output logic                           o_res_valid,
    output bpq_pkg::t_result               o_result,
    input  wire logic                      i_cfg_valid,
    input  wire logic [bpq_pkg::CNT_W-1:0] i_cfg_data
);
    import bpq_pkg::*;

    localparam int AW     = $clog2(DEPTH);
    localparam int PW_RAW = $clog2(DEPTH + 1);
    localparam int PW     = (PW_RAW > CNT_W) ? PW_RAW : CNT_W;
    localparam int CapMax = (DEPTH < 63) ? DEPTH : 63;

    t_entry r_mem [DEPTH];

    t_bk_state          r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [CNT_W-1:0]   r_cap;
    logic signed [31:0] r_high, n_high;
    logic signed [31:0] r_front, n_front;
    logic [1:0]         r_status, n_status;
    logic [PW-1:0]      r_rd_idx, n_rd_idx;
    logic [PW-1:0]      r_rd_pos, n_rd_pos;
    logic               r_rd_vld, n_rd_vld;
    logic               r_found, n_found;
    logic               r_any, n_any;
    logic signed [31:0] r_nmax, n_nmax;
    logic signed [31:0] r_nfront, n_nfront;
    t_entry             r_rd_data;

    logic [CNT_W-1:0] cap_eff;
    logic [PW-1:0]    cnt_ext;
    logic [PW-1:0]    pos_m1;
    logic             scan_done;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    t_entry           mem_wdata;

    assign cap_eff   = (r_cap > CNT_W'(CapMax)) ? CNT_W'(CapMax) : r_cap;
    assign cnt_ext   = PW'(r_cnt);
    assign pos_m1    = r_rd_pos - PW'(1);
    assign scan_done = ~r_rd_vld & (r_rd_idx == cnt_ext);
    assign rd_addr   = r_rd_idx[AW-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.op == OP_POP && r_cnt != '0) begin
                        n_state = BK_SCAN;
                    end else begin
                        n_state = BK_REPORT;
                    end
                end
            end
            BK_SCAN: begin
                if (scan_done) begin
                    n_state = BK_REPORT;
                end
            end
            BK_REPORT: begin
                if (i_res_space) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        o_cmd_take  = (r_state == BK_IDLE) & i_cmd_valid;
        o_res_valid = (r_state == BK_REPORT) & i_res_space;
    end

    always_comb begin
        o_result.front_value    = (r_cnt != '0) ? r_front : 32'sd0;
        o_result.front_priority = (r_cnt != '0) ? r_high : PRIO_MIN;
        o_result.entry_count    = r_cnt;
        o_result.is_empty       = (r_cnt == '0);
        o_result.is_full        = (r_cnt >= cap_eff);
        o_result.status         = r_status;
    end

    // datapath
    always_comb begin
        n_cnt     = r_cnt;
        n_high    = r_high;
        n_front   = r_front;
        n_status  = r_status;
        n_rd_idx  = r_rd_idx;
        n_rd_pos  = r_rd_pos;
        n_rd_vld  = 1'b0;
        n_found   = r_found;
        n_any     = r_any;
        n_nmax    = r_nmax;
        n_nfront  = r_nfront;
        rd_en     = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = cnt_ext[AW-1:0];
        mem_wdata = '{prio: i_cmd.prio, value: i_cmd.value};
        case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.op)
                        OP_PUSH: begin
                            if (r_cnt >= cap_eff) begin
                                n_status = ST_PUSH_FULL;
                            end else begin
                                n_status = ST_OK;
                                mem_we   = 1'b1;
                                n_cnt    = r_cnt + CNT_W'(1);
                                // a strictly higher priority becomes the new front
                                if (r_cnt == '0 || i_cmd.prio > r_high) begin
                                    n_high  = i_cmd.prio;
                                    n_front = i_cmd.value;
                                end
                            end
                        end
                        OP_POP: begin
                            if (r_cnt == '0) begin
                                n_status = ST_POP_EMPTY;
                            end else begin
                                n_status = ST_OK;
                                n_rd_idx = '0;
                                n_found  = 1'b0;
                                n_any    = 1'b0;
                                n_nmax   = PRIO_MIN;
                                n_nfront = 32'sd0;
                            end
                        end
                        default: n_status = ST_OK;
                    endcase
                end
            end
            BK_SCAN: begin
                // issue one read per cycle
                if (r_rd_idx < cnt_ext) begin
                    rd_en    = 1'b1;
                    n_rd_idx = r_rd_idx + PW'(1);
                end
                n_rd_vld = rd_en;
                n_rd_pos = r_rd_idx;
                // consume the registered read
                if (r_rd_vld) begin
                    if (!r_found && r_rd_data.prio == r_high) begin
                        n_found = 1'b1;
                    end else begin
                        if (r_found) begin
                            mem_we    = 1'b1;
                            mem_waddr = pos_m1[AW-1:0];
                            mem_wdata = r_rd_data;
                        end
                        if (!r_any || r_rd_data.prio > r_nmax) begin
                            n_any    = 1'b1;
                            n_nmax   = r_rd_data.prio;
                            n_nfront = r_rd_data.value;
                        end
                    end
                end
                if (scan_done) begin
                    n_cnt   = r_cnt - CNT_W'(1);
                    n_high  = r_any ? r_nmax : PRIO_MIN;
                    n_front = r_nfront;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_cnt    <= '0;
            r_cap    <= CAP_RESET;
            r_high   <= PRIO_MIN;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_high   <= n_high;
            r_rd_vld <= n_rd_vld;
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_front  <= n_front;
        r_status <= n_status;
        r_rd_idx <= n_rd_idx;
        r_rd_pos <= n_rd_pos;
        r_found  <= n_found;
        r_any    <= n_any;
        r_nmax   <= n_nmax;
        r_nfront <= n_nfront;
    end

    // entry memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/bounded_priority_queue_unit.sv
// bounded_priority_queue_unit: top level of the bounded priority queue
// depends on bpq_pkg, bpq_fifo, bpq_front and bpq_back
// the back takes no new item until the last result has gone into the result queue;
// a pop holds the back while it scans the entry memory through its single read port
// reset: synchronous active low; empties both queues, count 0, maximum to minimum,
// capacity_limit to 32; the entry memory is not cleared
`default_nettype none

module bounded_priority_queue_unit #(
    parameter int DEPTH = 32
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // item side
    input  wire logic                      push,
    output logic                           full,
    input  bpq_pkg::t_in_item              i_item,
    // result side
    output logic                           empty,
    input  wire logic                      pop,
    output bpq_pkg::t_result               o_result,
    // capacity register write
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [bpq_pkg::CNT_W-1:0] i_cfg_data
);
    import bpq_pkg::*;

    logic                       cmd_valid;
    t_cmd                       cmd;
    logic                       cmd_take;
    logic                       res_full;
    logic                       res_valid;
    t_result                    res;
    logic [$bits(t_result)-1:0] res_rdata;

    // capacity writes are always accepted
    assign o_cfg_ready = 1'b1;

    // front: decode and command queue, decouples item intake from execution
    bpq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    // back: owns count, maximum, front value and the entry memory
    bpq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .i_res_space (~res_full),
        .o_res_valid (res_valid),
        .o_result    (res),
        .i_cfg_valid (i_cfg_valid & o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // result queue lets the back move on while a result waits to be popped
    bpq_fifo #(
        .W ($bits(t_result))
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_valid),
        .i_wdata (res),
        .o_full  (res_full),
        .i_rd    (pop),
        .o_rdata (res_rdata),
        .o_empty (empty)
    );

    assign o_result = t_result'(res_rdata);

endmodule

`default_nettype wire

>>> hw/rtl/bpq_checker.sv
// bpq_port_checker: port-level checks of the bounded priority queue results
// depends on bpq_pkg; bound to bounded_priority_queue_unit below
`default_nettype none

module bpq_port_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      empty,
    input wire logic                      pop,
    input bpq_pkg::t_result               o_result
);
    import bpq_pkg::*;

    // no result is shown right after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result shown right after reset");

    // empty flag agrees with the count
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.is_empty == (o_result.entry_count == '0)))
        else $error("is_empty disagrees with entry_count");

    // an empty queue reports the fixed front
    a_empty_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.is_empty) |->
            (o_result.front_value == 32'sd0 && o_result.front_priority == PRIO_MIN))
        else $error("empty queue shows a front entry");

    // rejection codes match the flags
    a_reject_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((o_result.status != ST_PUSH_FULL || o_result.is_full) &&
                    (o_result.status != ST_POP_EMPTY || o_result.is_empty)))
        else $error("rejection status without matching flag");

    // a waiting result that is not popped stays
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result changed");

endmodule

bind bounded_priority_queue_unit bpq_port_checker u_bpq_port_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .empty       (empty),
    .pop         (pop),
    .o_result    (o_result)
);

`default_nettype wire

>>> test/bpq_checker.sv
// bpq_checker: predicts every result of the bounded priority queue and compares it
// watches the item, result and capacity channels; depends on bpq_pkg only
`timescale 1ns / 100ps

module bpq_checker #(
    parameter int DEPTH = 32
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_push,
    input  wire logic                      i_full,
    input  bpq_pkg::t_in_item              i_item,
    input  wire logic                      i_empty,
    input  wire logic                      i_pop,
    input  bpq_pkg::t_result               i_result,
    input  wire logic                      i_cfg_valid,
    input  wire logic                      i_cfg_ready,
    input  wire logic [bpq_pkg::CNT_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);

    import bpq_pkg::*;

    // shadow copy of the queue contents, in insertion order
    logic signed [31:0] slot_value [DEPTH];
    logic signed [31:0] slot_prio  [DEPTH];
    int                 held;
    logic signed [31:0] top_prio;
    logic [CNT_W-1:0]   capacity;
    t_result            expected_results [$];
    int                 fails = 0;

    function automatic int usable_capacity();
        return (capacity > DEPTH) ? DEPTH : int'(capacity);
    endfunction

    // earliest slot carrying the highest priority, held when none does
    function automatic int front_slot();
        int k;
        for (k = 0; k < held; k++) begin
            if (slot_prio[k] == top_prio) return k;
        end
        return held;
    endfunction

    function automatic t_result queue_after_item(t_in_item it);
        t_result    r;
        int         fi;
        int         k;
        logic [1:0] st;
        st = ST_OK;
        if (it.mode == MODE_PUSH) begin
            if (held >= usable_capacity() || held >= DEPTH) begin
                st = ST_PUSH_FULL;
            end else begin
                slot_value[held] = it.push_value;
                slot_prio[held]  = it.push_priority;
                held++;
                if ($signed(it.push_priority) > $signed(top_prio)) top_prio = it.push_priority;
            end
        end else if (it.mode == MODE_POP) begin
            if (held == 0) begin
                st = ST_POP_EMPTY;
            end else begin
                fi = front_slot();
                if (fi >= held) fi = held - 1;
                for (k = fi; k + 1 < held; k++) begin
                    slot_value[k] = slot_value[k + 1];
                    slot_prio[k]  = slot_prio[k + 1];
                end
                held--;
                top_prio = PRIO_MIN;
                for (k = 0; k < held; k++) begin
                    if (k == 0 || $signed(slot_prio[k]) > $signed(top_prio)) top_prio = slot_prio[k];
                end
            end
        end
        fi = front_slot();
        r.front_value    = (held > 0 && fi < held) ? slot_value[fi] : '0;
        r.front_priority = (held > 0) ? top_prio : PRIO_MIN;
        r.entry_count    = CNT_W'(held);
        r.is_empty       = (held == 0);
        r.is_full        = (held >= usable_capacity());
        r.status         = st;
        return r;
    endfunction

    task automatic check_result(t_result got);
        t_result want;
        bit      bad;
        if (expected_results.size() == 0) begin
            fails++;
            $display("%0t: result with no item waiting, expected none, got %h", $time, got);
            return;
        end
        want = expected_results.pop_front();
        bad  = 1'b0;
        if (got.front_value !== want.front_value) begin
            bad = 1'b1;
            $display("%0t: front_value expected %0d got %0d", $time,
                     $signed(want.front_value), $signed(got.front_value));
        end
        if (got.front_priority !== want.front_priority) begin
            bad = 1'b1;
            $display("%0t: front_priority expected %0d got %0d", $time,
                     $signed(want.front_priority), $signed(got.front_priority));
        end
        if (got.entry_count !== want.entry_count) begin
            bad = 1'b1;
            $display("%0t: entry_count expected %0d got %0d", $time,
                     want.entry_count, got.entry_count);
        end
        if (got.is_empty !== want.is_empty) begin
            bad = 1'b1;
            $display("%0t: is_empty expected %b got %b", $time, want.is_empty, got.is_empty);
        end
        if (got.is_full !== want.is_full) begin
            bad = 1'b1;
            $display("%0t: is_full expected %b got %b", $time, want.is_full, got.is_full);
        end
        if (got.status !== want.status) begin
            bad = 1'b1;
            $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
        end
        if (bad) fails++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held     = 0;
            top_prio = PRIO_MIN;
            capacity = CAP_RESET;
            expected_results.delete();
        end else begin
            if (i_pop && !i_empty) check_result(i_result);
            if (i_push && !i_full) expected_results.push_back(queue_after_item(i_item));
            if (i_cfg_valid && i_cfg_ready) capacity = i_cfg_data;
        end
        o_fail_count <= fails;
        o_pending    <= expected_results.size();
    end

endmodule

>>> test/tb_bounded_priority_queue_unit.sv
// tb_bounded_priority_queue_unit: stimulus and verdict for the bounded priority queue
// drives items, pops results and writes the capacity; checking lives in bpq_checker
// depends on bpq_pkg, bpq_checker and the bounded_priority_queue_unit rtl
`timescale 1ns / 100ps

module tb_bounded_priority_queue_unit;

    import bpq_pkg::*;

    localparam int DEPTH         = 32;
    // no handshake for this many cycles ends the run; covers the long hold-off
    // plus a full-depth pop and the random stalls on both sides
    localparam int STALL_LIMIT   = 4000;
    localparam int IDLE_PCT      = 26;
    localparam int HOLD_AFTER    = 400;   // items sent before the receiver holds off
    localparam int HOLD_CYCLES   = 400;
    localparam int STEADY_CYCLES = 1500;  // receiver pops every cycle after the hold-off
    localparam int DRAIN_CYCLES  = 60;    // covers the longest pop, a scan of every entry
    localparam int NUM_PHASES    = 8;
    localparam int NO_GAP_PHASE  = 5;     // sender offers an item every cycle here unless full
    localparam int RANDOM_CAP    = -1;

    localparam logic [1:0] MODE_STATUS = 2'(OP_STATUS);
    localparam logic [1:0] MODE_SPARE  = 2'd3;  // decodes as status only

    localparam logic signed [31:0] PRIO_MAX = 32'sh7fff_ffff;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               push        = 1'b0;
    logic               pop         = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic [CNT_W-1:0]   i_cfg_data  = '0;
    t_in_item           i_item      = '0;
    logic               full;
    logic               empty;
    logic               o_cfg_ready;
    t_result            o_result;

    int                 fail_count;
    int                 pending;
    int                 items_sent  = 0;
    bit                 sender_gaps = 1'b1;

    bounded_priority_queue_unit #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    bpq_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_full      (full),
        .i_item      (i_item),
        .i_empty     (empty),
        .i_pop       (pop),
        .i_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // 4 ns clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // offer one item; push stays high afterwards so back-to-back items never
    // drop and raise push in the same step
    task automatic send(input logic [1:0] mode, input logic signed [31:0] value,
                        input logic signed [31:0] prio);
        while (sender_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push   <= 1'b1;
        i_item <= {mode, value, prio};
        do @(posedge i_clk); while (full);
        items_sent++;
        @(negedge i_clk);
    endtask

    // capacity only changes while the queue has nothing in flight
    task automatic set_capacity(input logic [CNT_W-1:0] cap);
        push <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // operation mix for one phase; the rest splits between both status codes
    function automatic logic [1:0] pick_mode(int push_pct, int pop_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_pct) return MODE_PUSH;
        if (r < push_pct + pop_pct) return MODE_POP;
        return $urandom_range(0, 1) ? MODE_STATUS : MODE_SPARE;
    endfunction

    // mostly a narrow band so ties are common, with full-range and extreme values
    function automatic logic signed [31:0] pick_prio();
        int r;
        int p;
        r = $urandom_range(0, 99);
        p = $urandom_range(0, 7);
        if (r < 60) return p - 4;
        if (r < 80) return $urandom;
        if (r < 90) return PRIO_MIN;
        return PRIO_MAX;
    endfunction

    // main stimulus and verdict
    initial begin
        int ph;
        int n;
        int cap;
        int phase_cap  [NUM_PHASES] = '{32, 5, 63, 0, 1, 32, RANDOM_CAP, 2};
        int phase_push [NUM_PHASES] = '{70, 40, 65, 30, 50, 45, 55, 40};
        int phase_pop  [NUM_PHASES] = '{20, 50, 25, 60, 40, 45, 35, 55};
        int phase_len  [NUM_PHASES] = '{250, 150, 250, 100, 150, 300, 200, 200};

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty queue: status, pop rejected, spare mode code
        send(MODE_STATUS, 32'sd0, 32'sd0);
        send(MODE_POP, 32'sd0, 32'sd0);
        send(MODE_SPARE, -32'sd1, -32'sd1);
        // extreme values and priorities, with a tie at the top priority
        send(MODE_PUSH, PRIO_MIN, PRIO_MIN);
        send(MODE_PUSH, PRIO_MAX, 32'sd0);
        send(MODE_PUSH, -32'sd1, PRIO_MAX);
        send(MODE_PUSH, 32'sd0, PRIO_MAX);
        send(MODE_PUSH, 32'sd12345, -32'sd1);
        // drain: earliest of the tied entries first, the fifth pop restores the minimum, the last is rejected
        repeat (5) send(MODE_POP, 32'sd0, 32'sd0);
        send(MODE_POP, 32'sd0, 32'sd0);

        // capacity of one: second push is refused as full
        set_capacity(CNT_W'(1));
        send(MODE_PUSH, 32'sd7, 32'sd3);
        send(MODE_PUSH, 32'sd8, 32'sd4);
        send(MODE_STATUS, 32'sd0, 32'sd0);
        // capacity zero: full at once, pops still drain
        set_capacity(CNT_W'(0));
        send(MODE_PUSH, 32'sd9, 32'sd5);
        send(MODE_POP, 32'sd0, 32'sd0);
        send(MODE_PUSH, 32'sd10, 32'sd6);
        // capacity lowered below the count: pushes refused, nothing discarded
        set_capacity(CNT_W'(32));
        send(MODE_PUSH, 32'sd11, -32'sd2);
        send(MODE_PUSH, 32'sd12, 32'sd2);
        send(MODE_PUSH, 32'sd13, 32'sd2);
        set_capacity(CNT_W'(2));
        send(MODE_PUSH, 32'sd14, 32'sd9);
        repeat (3) send(MODE_POP, 32'sd0, 32'sd0);

        // random phases; the queue carries over so a lower capacity can
        // land below the count left by the phase before
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            cap = (phase_cap[ph] == RANDOM_CAP) ? $urandom_range(1, 63) : phase_cap[ph];
            set_capacity(CNT_W'(cap));
            sender_gaps = (ph != NO_GAP_PHASE);
            for (n = 0; n < phase_len[ph]; n++) begin
                send(pick_mode(phase_push[ph], phase_pop[ph]), $urandom, pick_prio());
            end
        end
        sender_gaps = 1'b1;

        push <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("bounded_priority_queue_unit verification clean");
        end else begin
            $display("bounded_priority_queue_unit verification failed");
        end
        $finish;
    end

    // result side: random pops, one long hold-off so the queue fills and
    // stalls the sender, then a stretch that pops every cycle
    initial begin
        bit hold_done;
        int k;
        hold_done = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!hold_done && items_sent >= HOLD_AFTER) begin
                hold_done = 1'b1;
                pop <= 1'b0;
                for (k = 0; k < HOLD_CYCLES; k++) @(negedge i_clk);
                for (k = 0; k < STEADY_CYCLES; k++) begin
                    pop <= 1'b1;
                    @(negedge i_clk);
                end
            end else begin
                pop <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // watchdog: any handshake on any channel resets the count
    initial begin
        int stall;
        stall = 0;
        @(posedge i_rst_n);
        while (stall < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
                stall = 0;
            end else begin
                stall++;
            end
        end
        $display("bounded_priority_queue_unit verification failed");
        $finish;
    end

endmodule
